/* src/csc_pkg.sv */
// Shared types, constants and operation codes of the collating string compare block.
// No dependencies; every other file takes what it needs from here by scoped name.
`default_nettype none

package csc_pkg;

  // Default depth of the left-string store.
  localparam int MAX_LEN_DEF = 64;

  localparam int FUNC_W  = 2;
  localparam int BYTE_W  = 8;
  localparam int ORDER_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LEFT_BYTE  = 2'd0,
    FUNC_LEFT_END   = 2'd1,
    FUNC_RIGHT_BYTE = 2'd2,
    FUNC_RIGHT_END  = 2'd3
  } func_t;

  typedef logic signed [ORDER_W-1:0] order_t;

  localparam order_t ORD_BEFORE = 2'sb11;
  localparam order_t ORD_EQUAL  = 2'sb00;
  localparam order_t ORD_AFTER  = 2'sb01;

endpackage

`default_nettype wire

/* src/csc_in_if.sv */
// Input channel of the collating string compare block: valid/ready plus one word.
// Depends on csc_pkg for the field widths.
`default_nettype none

interface csc_in_if;
  logic                          valid;
  logic                          ready;
  logic [csc_pkg::FUNC_W-1:0]    func;
  logic [csc_pkg::BYTE_W-1:0]    byte_in;

  modport source (output valid, output func, output byte_in, input ready);
  modport sink   (input valid, input func, input byte_in, output ready);
endinterface

`default_nettype wire

/* src/csc_out_if.sv */
// Result channel of the collating string compare block: valid/ready plus one word.
// Depends on csc_pkg for the field widths.
`default_nettype none

interface csc_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [csc_pkg::ORDER_W-1:0] order;
  logic                              overflow;

  modport source (output valid, output order, output overflow, input ready);
  modport sink   (input valid, input order, input overflow, output ready);
endinterface

`default_nettype wire

/* src/csc_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; the read returns the old contents on a same-address write.
`default_nettype none

module csc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* src/collating_string_compare_core.sv */
// Top level of the collating string compare block: state, compare logic and result register.
// Depends on csc_pkg, csc_in_if, csc_out_if and csc_ram.
`default_nettype none

//  Channel | Direction | Handshake        | Word
//  --------+-----------+------------------+---------------------------------------
//  in_ch   | in        | valid / ready    | func (2 bits), byte_in (8 bits)
//  out_ch  | out       | valid / ready    | order (2 bits, signed), overflow (1 bit)
//  cfg     | in        | cfg_we only      | cfg_wdata: upper_first (1 bit)
//
//  Every input word is handled in the cycle in which it is accepted, so while input is not
//  stalled the block takes one word per cycle, set by the single store read per right byte.
//  Only an end-of-right word produces a result; it appears in the cycle after acceptance and
//  is held in the result register until the sink takes it.
//  Input is stalled only while the result register is full and the sink is not taking it.
//  Reset (rst_n low, synchronous) clears all control state and sets upper_first; the store
//  contents are left as they are and need no clearing pass.

module collating_string_compare_core #(
  parameter int MAX_LEN = csc_pkg::MAX_LEN_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  csc_in_if.sink     in_ch,
  csc_out_if.source  out_ch,
  input  wire logic  cfg_we,
  input  wire logic  cfg_wdata
);

  localparam int LEN_W  = $clog2(MAX_LEN + 1);
  localparam int ADDR_W = $clog2(MAX_LEN);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LEN);

  // Character classes used by the collation rules.
  function automatic logic is_ws(input logic [7:0] b);
    return ((b >= 8'd9) && (b <= 8'd13)) || (b == 8'd32);
  endfunction

  function automatic logic is_up(input logic [7:0] b);
    return (b >= 8'd65) && (b <= 8'd90);
  endfunction

  function automatic logic is_low(input logic [7:0] b);
    return (b >= 8'd97) && (b <= 8'd122);
  endfunction

  function automatic logic [7:0] to_up(input logic [7:0] b);
    return is_low(b) ? (b - 8'd32) : b;
  endfunction

  // Comparison state.
  logic                upper_first_r;
  logic [LEN_W-1:0]    left_len_r, left_len_nxt;
  logic                left_trim_r, left_trim_nxt;
  logic                right_trim_r, right_trim_nxt;
  logic [LEN_W-1:0]    right_pos_r, right_pos_nxt;
  logic                decided_r, decided_nxt;
  csc_pkg::order_t     decision_r, decision_nxt;
  csc_pkg::order_t     case_tie_r, case_tie_nxt;
  logic                ovf_r, ovf_nxt;

  // Result register.
  logic                out_valid_r, out_valid_nxt;
  csc_pkg::order_t     out_order_r, out_order_nxt;
  logic                out_ovf_r, out_ovf_nxt;

  // Store ports and the same-cycle write bypass.
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [7:0]          ram_rdata;
  logic                byp_r;
  logic [7:0]          byp_data_r;
  logic [7:0]          left_byte;

  logic                in_acc;
  csc_pkg::func_t      func;
  logic [7:0]          rbyte;
  logic                both_letters;
  logic                good_case;

  // A new word is taken whenever the result register is empty or being emptied.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign func        = csc_pkg::func_t'(in_ch.func);
  assign rbyte       = in_ch.byte_in;

  // The read port fetches the entry at the next right position (entry 0 once past the store),
  // so the stored byte for the current position is ready in the read register when a right
  // byte arrives. A write to that same entry in the fetch cycle is forwarded past the RAM.
  assign left_byte    = byp_r ? byp_data_r : ram_rdata;
  assign both_letters = (is_up(left_byte) || is_low(left_byte)) && (is_up(rbyte) || is_low(rbyte));
  assign good_case    = upper_first_r ? is_up(left_byte) : is_low(left_byte);
  assign ram_waddr    = left_len_r[ADDR_W-1:0];
  assign ram_raddr    = (right_pos_nxt < LEN_MAX) ? right_pos_nxt[ADDR_W-1:0] : '0;

  always_comb begin
    left_len_nxt   = left_len_r;
    left_trim_nxt  = left_trim_r;
    right_trim_nxt = right_trim_r;
    right_pos_nxt  = right_pos_r;
    decided_nxt    = decided_r;
    decision_nxt   = decision_r;
    case_tie_nxt   = case_tie_r;
    ovf_nxt        = ovf_r;
    ram_we         = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_order_nxt  = out_order_r;
    out_ovf_nxt    = out_ovf_r;

    if (in_acc) begin
      unique case (func)
        csc_pkg::FUNC_LEFT_BYTE: begin
          // Leading whitespace is dropped; anything past the store depth only flags overflow.
          if (!(left_trim_r && is_ws(rbyte))) begin
            left_trim_nxt = 1'b0;
            if (left_len_r < LEN_MAX) begin
              ram_we       = 1'b1;
              left_len_nxt = left_len_r + LEN_W'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end
        end
        csc_pkg::FUNC_LEFT_END: begin
          right_trim_nxt = 1'b1;
          right_pos_nxt  = '0;
          decided_nxt    = 1'b0;
          decision_nxt   = csc_pkg::ORD_EQUAL;
          case_tie_nxt   = csc_pkg::ORD_EQUAL;
        end
        csc_pkg::FUNC_RIGHT_BYTE: begin
          if (!(right_trim_r && is_ws(rbyte))) begin
            right_trim_nxt = 1'b0;
            if (!decided_r) begin
              priority if (right_pos_r >= left_len_r) begin
                // The right string is longer than the left.
                decided_nxt  = 1'b1;
                decision_nxt = csc_pkg::ORD_BEFORE;
              end else if (left_byte == rbyte) begin
                right_pos_nxt = right_pos_r + LEN_W'(1);
              end else if (both_letters && (to_up(left_byte) == to_up(rbyte))) begin
                // Case twins: a wrong-way pair always wins, a right-way pair only sets an
                // empty tie.
                if (!good_case) begin
                  case_tie_nxt = csc_pkg::ORD_AFTER;
                end else if (case_tie_r == csc_pkg::ORD_EQUAL) begin
                  case_tie_nxt = csc_pkg::ORD_BEFORE;
                end
                right_pos_nxt = right_pos_r + LEN_W'(1);
              end else if (both_letters) begin
                decided_nxt  = 1'b1;
                decision_nxt = (to_up(left_byte) < to_up(rbyte)) ? csc_pkg::ORD_BEFORE
                                                                  : csc_pkg::ORD_AFTER;
              end else begin
                decided_nxt  = 1'b1;
                decision_nxt = ($signed(left_byte) < $signed(rbyte)) ? csc_pkg::ORD_BEFORE
                                                                      : csc_pkg::ORD_AFTER;
              end
            end
          end
        end
        csc_pkg::FUNC_RIGHT_END: begin
          out_valid_nxt = 1'b1;
          out_ovf_nxt   = ovf_r;
          priority if (decided_r) begin
            out_order_nxt = decision_r;
          end else if (right_pos_r < left_len_r) begin
            // The left string is longer than the right.
            out_order_nxt = csc_pkg::ORD_AFTER;
          end else begin
            out_order_nxt = case_tie_r;
          end
          right_trim_nxt = 1'b1;
          right_pos_nxt  = '0;
          decided_nxt    = 1'b0;
          decision_nxt   = csc_pkg::ORD_EQUAL;
          case_tie_nxt   = csc_pkg::ORD_EQUAL;
          left_len_nxt   = '0;
          left_trim_nxt  = 1'b1;
          ovf_nxt        = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_first_r <= 1'b1;
      left_len_r    <= '0;
      left_trim_r   <= 1'b1;
      right_trim_r  <= 1'b1;
      right_pos_r   <= '0;
      decided_r     <= 1'b0;
      decision_r    <= csc_pkg::ORD_EQUAL;
      case_tie_r    <= csc_pkg::ORD_EQUAL;
      ovf_r         <= 1'b0;
      out_valid_r   <= 1'b0;
      byp_r         <= 1'b0;
    end else begin
      if (cfg_we) begin
        upper_first_r <= cfg_wdata;
      end
      left_len_r    <= left_len_nxt;
      left_trim_r   <= left_trim_nxt;
      right_trim_r  <= right_trim_nxt;
      right_pos_r   <= right_pos_nxt;
      decided_r     <= decided_nxt;
      decision_r    <= decision_nxt;
      case_tie_r    <= case_tie_nxt;
      ovf_r         <= ovf_nxt;
      out_valid_r   <= out_valid_nxt;
      byp_r         <= ram_we && (ram_waddr == ram_raddr);
    end
  end

  always_ff @(posedge clk) begin
    out_order_r <= out_order_nxt;
    out_ovf_r   <= out_ovf_nxt;
    byp_data_r  <= rbyte;
  end

  csc_ram #(
    .WIDTH (8),
    .DEPTH (MAX_LEN)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (rbyte),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_ch.valid    = out_valid_r;
  assign out_ch.order    = out_order_r;
  assign out_ch.overflow = out_ovf_r;

  // The right position never runs past the stored left string.
  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    right_pos_r <= left_len_r) else $error("right position beyond left length");

  // Overflow can only be flagged once the store is full.
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (left_len_r == LEN_MAX)) else $error("overflow with store not full");

  // A settled comparison always carries a non-equal decision.
  a_decision: assert property (@(posedge clk) disable iff (!rst_n)
    decided_r |-> (decision_r != csc_pkg::ORD_EQUAL)) else $error("decided without order");

  // An accepted end of right string leaves a result waiting next cycle and clears the state.
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (func == csc_pkg::FUNC_RIGHT_END)) |=> (out_valid_r && (left_len_r == '0)))
    else $error("end of right string gave no result");

endmodule

`default_nettype wire
